### rtl/core/cycle_counter_calibrator_defines.svh
// Assertion macros for the cycle counter calibrator checker.
`ifndef CYCLE_COUNTER_CALIBRATOR_DEFINES_SVH
`define CYCLE_COUNTER_CALIBRATOR_DEFINES_SVH

// Check a property on rising clk, off while reset is low.
`define CCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ccc check failed");

// Check a property on rising clk, also during reset.
`define CCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ccc check failed");

`endif

### rtl/core/ccc_pkg.sv
// Shared types and constants of the cycle counter calibrator.
package ccc_pkg;

  localparam int DELTA_WIDTH = 48;
  localparam int TICK_W      = 16;
  localparam int REF_W       = 32;
  localparam int US_W        = 36;
  localparam int FNUM_W      = US_W + 32;
  localparam int UW          = (DELTA_WIDTH + REF_W > FNUM_W) ? DELTA_WIDTH + REF_W : FNUM_W;
  localparam int PW          = DELTA_WIDTH + TICK_W;
  localparam int RW          = PW + 8;
  localparam int CNT_W       = 7;

  localparam logic [7:0] END_QUICK  = 8'd224;
  localparam logic [7:0] END_SLOWER = 8'd192;
  localparam logic [7:0] END_SLOW   = 8'd128;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [39:0] CPU_HZ_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] FACTOR_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_MAX_QUICK = 2'd0;
  localparam logic [1:0] REG_MAX_SLOW  = 2'd1;
  localparam logic [1:0] REG_REF_HZ    = 2'd2;
  localparam logic [1:0] REG_TOL       = 2'd3;

  typedef enum logic {OP_MUL, OP_DIV} unit_op_t;

  typedef struct packed {
    logic             start;
    unit_op_t         op;
    logic [CNT_W-1:0] steps;
    logic [UW-1:0]    a;
    logic [UW-1:0]    b;
  } unit_req_t;

  typedef struct packed {
    logic          done;
    logic [UW-1:0] result;
  } unit_rsp_t;

endpackage

### rtl/core/cycle_counter_calibrator.sv
// Top level of the cycle counter calibrator: registers, sequencer, result register.
//
//  channel  direction  handshake                      payload
//  in       request    in_valid / in_ready            in_tsc_delta, in_elapsed_ticks
//  out      result     out_valid / out_ready          out_* fields
//  cfg      write/read psel penable pwrite pready     paddr, pwdata, prdata
//
// A quick measurement needs no arithmetic. A ratio check adds two multiplies in the
// shared unit and a bounds compare; completion adds a multiply and two divides,
// all in the one shift-add/subtract unit.
// Reset is synchronous, active low, and restores register defaults and phase 0.
// in_ready is high only while the sequencer idles; a stalled result holds in the output
// register and the next request is taken while it waits.
module cycle_counter_calibrator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ccc_pkg::DELTA_WIDTH-1:0] in_tsc_delta,
  input  logic [15:0]                     in_elapsed_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_next_end_high_byte,
  output logic                            out_done_res,
  output logic                            out_divide_fault,
  output logic [39:0]                     out_cpu_hz,
  output logic [31:0]                     out_time_factor,
  output logic [6:0]                      out_quick_tries,
  output logic [6:0]                      out_slow_tries,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_MULN     = 13'b0000000000100,
    S_MULD     = 13'b0000000001000,
    S_CMPLO    = 13'b0000000010000,
    S_CMPHI    = 13'b0000000100000,
    S_DECIDE   = 13'b0000001000000,
    S_MULS     = 13'b0000010000000,
    S_HZ       = 13'b0000100000000,
    S_DIVH     = 13'b0001000000000,
    S_FAC      = 13'b0010000000000,
    S_DIVF     = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  localparam int DW = ccc_pkg::DELTA_WIDTH;
  localparam int CW = ccc_pkg::CNT_W;

  state_t state_r, state_nxt;

  logic [5:0]  max_quick_r, max_slow_r, tol_r;
  logic [31:0] ref_hz_r;

  logic [1:0]    phase_r, phase_nxt;
  logic [DW-1:0] quick_delta_r, quick_delta_nxt, slower_delta_r, slower_delta_nxt;
  logic [15:0]   quick_ticks_r, quick_ticks_nxt, slower_ticks_r, slower_ticks_nxt;
  logic [CW-1:0] qc_r, qc_nxt, sc_r, sc_nxt;

  logic [DW-1:0]          cur_delta_r, cur_delta_nxt;
  logic [15:0]            cur_ticks_r, cur_ticks_nxt;
  logic                   fault_r, fault_nxt, done_r, done_nxt, lo_ok_r, lo_ok_nxt;
  logic                   ok_r, ok_nxt;
  logic [7:0]             next_r, next_nxt;
  logic [39:0]            hz_r, hz_nxt;
  logic [31:0]            fac_r, fac_nxt;
  logic [ccc_pkg::PW-1:0] num_r, num_nxt, den_r, den_nxt;
  logic [ccc_pkg::UW-1:0] scaled_r, scaled_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             o_next_r, o_next_nxt;
  logic                   o_done_r, o_done_nxt, o_fault_r, o_fault_nxt;
  logic [39:0]            o_hz_r, o_hz_nxt;
  logic [31:0]            o_fac_r, o_fac_nxt;
  logic [CW-1:0]          o_qt_r, o_qt_nxt, o_st_r, o_st_nxt;

  logic [DW-1:0]             sel_d;
  logic [15:0]               sel_t;
  logic [ccc_pkg::RW-1:0]    lhs, bound;
  logic [ccc_pkg::US_W-1:0]  us;
  logic [ccc_pkg::FNUM_W-1:0] fnum;
  logic                      wr_en;
  ccc_pkg::unit_req_t        req;
  ccc_pkg::unit_rsp_t        rsp;

  ccc_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_quick_r <= 6'd20;
      max_slow_r  <= 6'd20;
      ref_hz_r    <= 32'd1193181;
      tol_r       <= 6'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ccc_pkg::REG_MAX_QUICK: max_quick_r <= pwdata[5:0];
        ccc_pkg::REG_MAX_SLOW:  max_slow_r  <= pwdata[5:0];
        ccc_pkg::REG_REF_HZ:    ref_hz_r    <= pwdata;
        ccc_pkg::REG_TOL:       tol_r       <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ccc_pkg::REG_MAX_QUICK: prdata = {26'd0, max_quick_r};
      ccc_pkg::REG_MAX_SLOW:  prdata = {26'd0, max_slow_r};
      ccc_pkg::REG_REF_HZ:    prdata = ref_hz_r;
      ccc_pkg::REG_TOL:       prdata = {26'd0, tol_r};
      default:                prdata = '0;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign sel_d     = (phase_r == 2'd1) ? quick_delta_r : slower_delta_r;
  assign sel_t     = (phase_r == 2'd1) ? quick_ticks_r : slower_ticks_r;
  assign lhs       = ccc_pkg::RW'(num_r) * ccc_pkg::RW'(100);
  assign bound     = ccc_pkg::RW'(den_r) *
                     ((state_r == S_CMPLO) ? ccc_pkg::RW'(8'd100 - {2'b00, tol_r})
                                           : ccc_pkg::RW'(8'd100 + {2'b00, tol_r}));
  assign us        = ccc_pkg::US_W'(cur_ticks_r) * ccc_pkg::US_W'(ccc_pkg::USEC_PER_SEC);
  assign fnum      = {us, 32'd0};

  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    quick_delta_nxt  = quick_delta_r;
    quick_ticks_nxt  = quick_ticks_r;
    slower_delta_nxt = slower_delta_r;
    slower_ticks_nxt = slower_ticks_r;
    qc_nxt           = qc_r;
    sc_nxt           = sc_r;
    cur_delta_nxt    = cur_delta_r;
    cur_ticks_nxt    = cur_ticks_r;
    fault_nxt        = fault_r;
    done_nxt         = done_r;
    lo_ok_nxt        = lo_ok_r;
    ok_nxt           = ok_r;
    next_nxt         = next_r;
    hz_nxt           = hz_r;
    fac_nxt          = fac_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    scaled_nxt       = scaled_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    o_next_nxt       = o_next_r;
    o_done_nxt       = o_done_r;
    o_fault_nxt      = o_fault_r;
    o_hz_nxt         = o_hz_r;
    o_fac_nxt        = o_fac_r;
    o_qt_nxt         = o_qt_r;
    o_st_nxt         = o_st_r;
    req.start        = 1'b0;
    req.op           = ccc_pkg::OP_MUL;
    req.steps        = CW'(16);
    req.a            = ccc_pkg::UW'(sel_d);
    req.b            = ccc_pkg::UW'(cur_ticks_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_delta_nxt = in_tsc_delta;
          cur_ticks_nxt = in_elapsed_ticks;
          fault_nxt     = (in_tsc_delta == '0) || (in_elapsed_ticks == '0);
          done_nxt      = 1'b0;
          hz_nxt        = '0;
          fac_nxt       = '0;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (phase_r == 2'd1 || phase_r == 2'd2) begin
          if (sel_d == '0 || sel_t == '0 || cur_delta_r == '0 || cur_ticks_r == '0) begin
            ok_nxt    = 1'b0;
            state_nxt = S_DECIDE;
          end else begin
            req.start = 1'b1;
            state_nxt = S_MULN;
          end
        end else begin
          quick_delta_nxt = cur_delta_r;
          quick_ticks_nxt = cur_ticks_r;
          phase_nxt       = 2'd1;
          next_nxt        = ccc_pkg::END_SLOWER;
          state_nxt       = S_FIN;
        end
      end
      S_MULN: begin
        req.a = ccc_pkg::UW'(cur_delta_r);
        req.b = ccc_pkg::UW'(sel_t);
        if (rsp.done) begin
          num_nxt   = rsp.result[ccc_pkg::PW-1:0];
          req.start = 1'b1;
          state_nxt = S_MULD;
        end
      end
      S_MULD: begin
        if (rsp.done) begin
          den_nxt   = rsp.result[ccc_pkg::PW-1:0];
          state_nxt = S_CMPLO;
        end
      end
      S_CMPLO: begin
        lo_ok_nxt = lhs >= bound;
        state_nxt = S_CMPHI;
      end
      S_CMPHI: begin
        ok_nxt    = lo_ok_r && (lhs <= bound);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        req.a = ccc_pkg::UW'(cur_delta_r);
        req.b = ccc_pkg::UW'(ref_hz_r);
        if (phase_r == 2'd1) begin
          if (!ok_r && qc_r < {1'b0, max_quick_r}) begin
            qc_nxt    = qc_r + 1'b1;
            phase_nxt = 2'd0;
            next_nxt  = ccc_pkg::END_QUICK;
          end else begin
            slower_delta_nxt = cur_delta_r;
            slower_ticks_nxt = cur_ticks_r;
            phase_nxt        = 2'd2;
            next_nxt         = ccc_pkg::END_SLOW;
          end
          state_nxt = S_FIN;
        end else if (!ok_r && sc_r < {1'b0, max_slow_r}) begin
          sc_nxt    = sc_r + 1'b1;
          phase_nxt = 2'd1;
          next_nxt  = ccc_pkg::END_SLOWER;
          state_nxt = S_FIN;
        end else begin
          done_nxt  = 1'b1;
          phase_nxt = 2'd0;
          next_nxt  = ccc_pkg::END_QUICK;
          req.start = 1'b1;
          req.steps = CW'(ccc_pkg::REF_W);
          state_nxt = S_MULS;
        end
      end
      S_MULS: begin
        if (rsp.done) begin
          scaled_nxt = rsp.result;
          state_nxt  = S_HZ;
        end
      end
      S_HZ: begin
        req.op    = ccc_pkg::OP_DIV;
        req.steps = CW'(ccc_pkg::UW);
        req.a     = scaled_r;
        if (cur_ticks_r == '0) begin
          hz_nxt    = ccc_pkg::CPU_HZ_MAX;
          state_nxt = S_FAC;
        end else begin
          req.start = 1'b1;
          state_nxt = S_DIVH;
        end
      end
      S_DIVH: begin
        if (rsp.done) begin
          hz_nxt    = (|rsp.result[ccc_pkg::UW-1:40]) ? ccc_pkg::CPU_HZ_MAX
                                                      : rsp.result[39:0];
          state_nxt = S_FAC;
        end
      end
      S_FAC: begin
        req.op    = ccc_pkg::OP_DIV;
        req.steps = CW'(ccc_pkg::FNUM_W);
        req.a     = ccc_pkg::UW'(fnum) << (ccc_pkg::UW - ccc_pkg::FNUM_W);
        req.b     = scaled_r;
        if (scaled_r == '0) begin
          fault_nxt = 1'b1;
          fac_nxt   = ccc_pkg::FACTOR_MAX;
          state_nxt = S_FIN;
        end else begin
          req.start = 1'b1;
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        if (rsp.done) begin
          fac_nxt   = (|rsp.result[ccc_pkg::UW-1:32]) ? ccc_pkg::FACTOR_MAX
                                                      : rsp.result[31:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_next_nxt    = next_r;
          o_done_nxt    = done_r;
          o_fault_nxt   = fault_r;
          o_hz_nxt      = hz_r;
          o_fac_nxt     = fac_r;
          o_qt_nxt      = qc_r;
          o_st_nxt      = sc_r;
          if (done_r) begin
            qc_nxt = CW'(1);
            sc_nxt = CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= 2'd0;
      quick_delta_r  <= '0;
      quick_ticks_r  <= '0;
      slower_delta_r <= '0;
      slower_ticks_r <= '0;
      qc_r           <= CW'(1);
      sc_r           <= CW'(1);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      quick_delta_r  <= quick_delta_nxt;
      quick_ticks_r  <= quick_ticks_nxt;
      slower_delta_r <= slower_delta_nxt;
      slower_ticks_r <= slower_ticks_nxt;
      qc_r           <= qc_nxt;
      sc_r           <= sc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cur_delta_r <= cur_delta_nxt;
    cur_ticks_r <= cur_ticks_nxt;
    fault_r     <= fault_nxt;
    done_r      <= done_nxt;
    lo_ok_r     <= lo_ok_nxt;
    ok_r        <= ok_nxt;
    next_r      <= next_nxt;
    hz_r        <= hz_nxt;
    fac_r       <= fac_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    scaled_r    <= scaled_nxt;
    o_next_r    <= o_next_nxt;
    o_done_r    <= o_done_nxt;
    o_fault_r   <= o_fault_nxt;
    o_hz_r      <= o_hz_nxt;
    o_fac_r     <= o_fac_nxt;
    o_qt_r      <= o_qt_nxt;
    o_st_r      <= o_st_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_next_end_high_byte = o_next_r;
  assign out_done_res           = o_done_r;
  assign out_divide_fault       = o_fault_r;
  assign out_cpu_hz             = o_hz_r;
  assign out_time_factor        = o_fac_r;
  assign out_quick_tries        = o_qt_r;
  assign out_slow_tries         = o_st_r;

endmodule

### rtl/core/ccc_unit.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module ccc_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  ccc_pkg::unit_req_t req,
  output ccc_pkg::unit_rsp_t rsp
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  ccc_pkg::unit_op_t         op_r, op_nxt;
  logic [ccc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ccc_pkg::UW-1:0]    a_r, a_nxt;
  logic [ccc_pkg::UW-1:0]    b_r, b_nxt;
  logic [ccc_pkg::UW-1:0]    acc_r, acc_nxt;
  logic [ccc_pkg::UW:0]      rem_r, rem_nxt;
  logic [ccc_pkg::UW:0]      rem_sh;
  logic                      fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r[ccc_pkg::UW-1:0], a_r[ccc_pkg::UW-1]};
    fits     = rem_sh >= {1'b0, b_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = req.steps;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      unique case (op_r)
        ccc_pkg::OP_MUL: begin
          if (b_r[0]) acc_nxt = acc_r + a_r;
          a_nxt = {a_r[ccc_pkg::UW-2:0], 1'b0};
          b_nxt = {1'b0, b_r[ccc_pkg::UW-1:1]};
        end
        ccc_pkg::OP_DIV: begin
          rem_nxt = fits ? rem_sh - {1'b0, b_r} : rem_sh;
          acc_nxt = {acc_r[ccc_pkg::UW-2:0], fits};
          a_nxt   = {a_r[ccc_pkg::UW-2:0], 1'b0};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ccc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

### rtl/core/ccc_checker.sv
// Port-level checker of the cycle counter calibrator and its bind.
`include "cycle_counter_calibrator_defines.svh"

module ccc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_next_end_high_byte,
  input logic       out_done_res
);

  logic end_quick;
  logic end_legal;

  assign end_quick = (out_next_end_high_byte == ccc_pkg::END_QUICK);
  assign end_legal = end_quick ||
                     (out_next_end_high_byte == ccc_pkg::END_SLOWER) ||
                     (out_next_end_high_byte == ccc_pkg::END_SLOW);

  `CCC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `CCC_ASSERT(a_busy_after_request, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `CCC_ASSERT(a_done_restarts, clk, rst_n, out_valid && out_done_res |-> end_quick)
  `CCC_ASSERT(a_end_byte_legal, clk, rst_n, out_valid |-> end_legal)

endmodule

bind cycle_counter_calibrator ccc_checker u_ccc_checker (.*);
